FILE: design/linear_quadtree_cell_index_top_macros.svh
// Assertion macros shared by the modules that check their own logic.
// Both sample on the rising edge of clk and are held off while rst_n is low.
`ifndef LINEAR_QUADTREE_CELL_INDEX_TOP_MACROS_SVH
`define LINEAR_QUADTREE_CELL_INDEX_TOP_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define LQCI_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LQCI_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: design/lqci_pkg.sv
`timescale 1ns / 1ps

package lqci_pkg;

    localparam int MAX_LEVELS  = 8;
    localparam int FIELD_SIZE  = 1280;
    localparam int COORD_IN_W  = 12;
    localparam int CFG_W       = 4;
    localparam int LEVEL_W     = 4;
    localparam int INDEX_W     = 17;
    localparam int COORD_W     = $clog2(FIELD_SIZE);
    localparam int SCALED_W    = COORD_W + MAX_LEVELS;
    localparam int CELL_W      = MAX_LEVELS;
    localparam int MORTON_W    = 2 * MAX_LEVELS;
    localparam int RECIP_SHIFT = SCALED_W + COORD_W;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + FIELD_SIZE - 1) / FIELD_SIZE;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = SCALED_W + RECIP_W;

    localparam logic [CFG_W-1:0] RESET_RESOLUTION = 4'd3;

    typedef struct packed {
        logic signed [COORD_IN_W-1:0] left_x;
        logic signed [COORD_IN_W-1:0] top_y;
        logic signed [COORD_IN_W-1:0] right_x;
        logic signed [COORD_IN_W-1:0] bottom_y;
    } box_t;

    typedef struct packed {
        logic [INDEX_W-1:0] cell_index;
        logic [LEVEL_W-1:0] tree_level;
    } cell_t;

    typedef struct packed {
        logic [SCALED_W-1:0] left_x;
        logic [SCALED_W-1:0] top_y;
        logic [SCALED_W-1:0] right_x;
        logic [SCALED_W-1:0] bottom_y;
        logic [LEVEL_W-1:0]  res;
    } scaled_t;

    typedef struct packed {
        logic [CELL_W-1:0]  left_x;
        logic [CELL_W-1:0]  top_y;
        logic [CELL_W-1:0]  right_x;
        logic [CELL_W-1:0]  bottom_y;
        logic [LEVEL_W-1:0] res;
    } grid_t;

    typedef struct packed {
        logic [MORTON_W-1:0] rd_code;
        logic [LEVEL_W-1:0]  lift;
        logic [LEVEL_W-1:0]  level;
    } span_t;

endpackage

FILE: design/lqci_scale.sv
`timescale 1ns / 1ps

module lqci_scale
    import lqci_pkg::*;
(
    input  logic               clk,
    input  logic               load,
    input  box_t               box,
    input  logic [LEVEL_W-1:0] res,
    output scaled_t            scaled
);

    scaled_t scaled_reg;
    scaled_t scaled_next;

    // Coordinates outside the field are pulled onto its nearest edge.
    function automatic logic [SCALED_W-1:0] clamp_shift(
        input logic signed [COORD_IN_W-1:0] v,
        input logic [LEVEL_W-1:0]           sh
    );
        logic [SCALED_W-1:0] c;
        if (v < 0)
            c = '0;
        else if (int'(v) > FIELD_SIZE - 1)
            c = SCALED_W'(FIELD_SIZE - 1);
        else
            c = SCALED_W'($unsigned(v));
        return c << sh;
    endfunction

    always_comb
    begin
        scaled_next.left_x   = clamp_shift(box.left_x, res);
        scaled_next.top_y    = clamp_shift(box.top_y, res);
        scaled_next.right_x  = clamp_shift(box.right_x, res);
        scaled_next.bottom_y = clamp_shift(box.bottom_y, res);
        scaled_next.res      = res;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

FILE: design/lqci_grid.sv
`timescale 1ns / 1ps

module lqci_grid
    import lqci_pkg::*;
(
    input  logic    clk,
    input  logic    load,
    input  scaled_t scaled,
    output grid_t   grid
);

    grid_t grid_reg;
    grid_t grid_next;

    // Division by the field size as a multiplication by its rounded-up
    // reciprocal; the shift is wide enough for the quotient to be exact.
    function automatic logic [CELL_W-1:0] to_cell(input logic [SCALED_W-1:0] x);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(RECIP);
        return p[RECIP_SHIFT +: CELL_W];
    endfunction

    always_comb
    begin
        grid_next.left_x   = to_cell(scaled.left_x);
        grid_next.top_y    = to_cell(scaled.top_y);
        grid_next.right_x  = to_cell(scaled.right_x);
        grid_next.bottom_y = to_cell(scaled.bottom_y);
        grid_next.res      = scaled.res;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grid_reg <= grid_next;
        end
    end

    assign grid = grid_reg;

endmodule

FILE: design/lqci_level.sv
`timescale 1ns / 1ps

module lqci_level
    import lqci_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  grid_t grid,
    output span_t span
);

    span_t span_reg;
    span_t span_next;

    function automatic logic [MORTON_W-1:0] interleave(
        input logic [CELL_W-1:0] cx,
        input logic [CELL_W-1:0] cy
    );
        logic [MORTON_W-1:0] m;
        for (int i = 0; i < CELL_W; i++)
        begin
            m[2*i]   = cx[i];
            m[2*i+1] = cy[i];
        end
        return m;
    endfunction

    logic [MORTON_W-1:0] lu_code;
    logic [MORTON_W-1:0] rd_code;
    logic [MORTON_W-1:0] diff;
    logic [LEVEL_W-1:0]  lift;

    always_comb
    begin
        lu_code = interleave(grid.left_x, grid.top_y);
        rd_code = interleave(grid.right_x, grid.bottom_y);
        diff    = lu_code ^ rd_code;
        // The highest differing bit pair sets how far the box is lifted.
        lift = '0;
        for (int p = 0; p < MAX_LEVELS; p++)
        begin
            if (diff[2*p] || diff[2*p+1])
                lift = LEVEL_W'(p + 1);
        end
        span_next.rd_code = rd_code;
        span_next.lift    = lift;
        span_next.level   = grid.res - lift;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            span_reg <= span_next;
        end
    end

    assign span = span_reg;

endmodule

FILE: design/lqci_index.sv
`timescale 1ns / 1ps

module lqci_index
    import lqci_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  span_t span,
    output cell_t cell_word
);

    cell_t cell_reg;
    cell_t cell_next;

    // Number of cells on all levels above the given one, (4^level - 1) / 3.
    function automatic logic [INDEX_W-1:0] level_offset(input logic [LEVEL_W-1:0] lvl);
        logic [INDEX_W-1:0] o;
        o = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if (LEVEL_W'(i) < lvl)
                o[2*i] = 1'b1;
        end
        return o;
    endfunction

    logic [MORTON_W-1:0] code;

    always_comb
    begin
        code = span.rd_code >> {span.lift, 1'b0};
        cell_next.cell_index = INDEX_W'(code) + level_offset(span.level);
        cell_next.tree_level = span.level;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_word = cell_reg;

endmodule

FILE: design/linear_quadtree_cell_index_top.sv
// Channel  Direction  Handshake            Word
// box      in         box_valid/box_stall  box_t: left_x, top_y, right_x, bottom_y
// cell     out        cell_valid/cell_stall cell_t: cell_index, tree_level
// res      in         res_valid/res_ready  resolution, 4 bits
//
// One box enters per cycle while box_stall is low; its result passes through each
// stage register in turn before it is shown on cell_valid.
// The stages are clamp and scale, reciprocal multiply, interleave and level
// search, then shift and offset add into the output register.
// Each stage advances when the one after it is empty or moving, so bubbles close up.
// Reset clears all valid bits and sets the resolution to 3; res_ready is always high.
`timescale 1ns / 1ps
`include "linear_quadtree_cell_index_top_macros.svh"

module linear_quadtree_cell_index_top
    import lqci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             box_valid,
    output logic             box_stall,
    input  box_t             box,
    output logic             cell_valid,
    input  logic             cell_stall,
    output cell_t            cell_word,
    input  logic             res_valid,
    output logic             res_ready,
    input  logic [CFG_W-1:0] res_data
);

    logic [CFG_W-1:0]   resolution_reg;
    logic [LEVEL_W-1:0] res_eff;

    logic    s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic    s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next;
    logic    s1_ready, s2_ready, s3_ready, s4_ready;
    scaled_t scaled;
    grid_t   grid;
    span_t   span;

    assign res_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            resolution_reg <= RESET_RESOLUTION;
        else if (res_valid && res_ready)
            resolution_reg <= res_data;
    end

    assign res_eff = (resolution_reg > CFG_W'(MAX_LEVELS)) ? LEVEL_W'(MAX_LEVELS)
                                                          : LEVEL_W'(resolution_reg);

    assign s4_ready  = !s4_valid_reg || !cell_stall;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign box_stall = !s1_ready;

    always_comb
    begin
        s1_valid_next = s1_ready ? box_valid    : s1_valid_reg;
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_ready ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
        end
    end

    lqci_scale u_scale (
        .clk    (clk),
        .load   (s1_ready),
        .box    (box),
        .res    (res_eff),
        .scaled (scaled)
    );

    lqci_grid u_grid (
        .clk    (clk),
        .load   (s2_ready),
        .scaled (scaled),
        .grid   (grid)
    );

    lqci_level u_level (
        .clk  (clk),
        .load (s3_ready),
        .grid (grid),
        .span (span)
    );

    lqci_index u_index (
        .clk       (clk),
        .load      (s4_ready),
        .span      (span),
        .cell_word (cell_word)
    );

    assign cell_valid = s4_valid_reg;

    `LQCI_ASSERT_NEXT(a_accept_fills, box_valid && !box_stall, s1_valid_reg, "accepted box lost at entry")
    `LQCI_ASSERT_NEXT(a_s1_moves, s1_valid_reg && s2_ready, s2_valid_reg, "word lost between first stages")
    `LQCI_ASSERT_NEXT(a_s3_moves, s3_valid_reg && s4_ready, cell_valid, "word lost before output")
    `LQCI_ASSERT_IMPL(a_level_range, cell_valid, cell_word.tree_level <= res_eff, "level above resolution")

endmodule

FILE: dv/cell_index_checker.sv
`timescale 1ns / 1ps

module cell_index_checker
    import lqci_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             box_valid,
    input  logic             box_stall,
    input  box_t             box_word,
    input  logic             cell_valid,
    input  logic             cell_stall,
    input  cell_t            cell_word,
    input  logic             res_valid,
    input  logic             res_ready,
    input  logic [CFG_W-1:0] res_data,
    output int               mismatches,
    output int               outstanding
);

    cell_t            cells_due[$];
    cell_t            due;
    logic [CFG_W-1:0] resolution;

    function automatic int grid_coord(logic signed [COORD_IN_W-1:0] raw, int depth);
        int v;
        v = raw;
        if (v < 0)
        begin
            v = 0;
        end
        else if (v > FIELD_SIZE - 1)
        begin
            v = FIELD_SIZE - 1;
        end
        return (v << depth) / FIELD_SIZE;
    endfunction

    function automatic logic [MORTON_W-1:0] interleave(int gx, int gy);
        logic [MORTON_W-1:0] code;
        code = '0;
        for (int i = 0; i < CELL_W; i++)
        begin
            code[2 * i]     = gx[i];
            code[2 * i + 1] = gy[i];
        end
        return code;
    endfunction

    function automatic cell_t locate_cell(box_t b, logic [CFG_W-1:0] res_reg);
        int                  depth;
        int                  level;
        int                  offset;
        logic [MORTON_W-1:0] upper_left;
        logic [MORTON_W-1:0] lower_right;
        logic [MORTON_W-1:0] diff;
        cell_t               found;
        depth = (res_reg > MAX_LEVELS) ? MAX_LEVELS : int'(res_reg);
        upper_left  = interleave(grid_coord(b.left_x, depth), grid_coord(b.top_y, depth));
        lower_right = interleave(grid_coord(b.right_x, depth), grid_coord(b.bottom_y, depth));
        diff  = upper_left ^ lower_right;
        level = depth;
        while (diff != 0 && level > 0)
        begin
            diff = diff >> 2;
            level--;
        end
        offset = ((1 << (2 * level)) - 1) / 3;
        found.cell_index = INDEX_W'(int'(lower_right >> (2 * (depth - level))) + offset);
        found.tree_level = LEVEL_W'(level);
        return found;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution = RESET_RESOLUTION;
            cells_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                resolution = res_data;
            end
            if (cell_valid && !cell_stall)
            begin
                if (cells_due.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected cell word: index %0d level %0d",
                                 cell_word.cell_index, cell_word.tree_level);
                    end
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    due = cells_due.pop_front();
                    if (cell_word.cell_index !== due.cell_index ||
                        cell_word.tree_level !== due.tree_level)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("cell mismatch: expected index %0d level %0d, got index %0d level %0d",
                                     due.cell_index, due.tree_level,
                                     cell_word.cell_index, cell_word.tree_level);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (box_valid && !box_stall)
            begin
                cells_due = {cells_due, locate_cell(box_word, resolution)};
            end
            outstanding <= cells_due.size();
        end
    end

endmodule

FILE: dv/linear_quadtree_cell_index_top_tb.sv
`timescale 1ns / 1ps

module linear_quadtree_cell_index_top_tb;
    import lqci_pkg::*;

    localparam int STUCK_LIMIT = 1000;
    localparam int PHASE_ITEMS = 68;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             box_valid  = 1'b0;
    logic             box_stall;
    box_t             box_word   = '0;
    logic             cell_valid;
    logic             cell_stall = 1'b0;
    cell_t            cell_word;
    logic             res_valid  = 1'b0;
    logic             res_ready;
    logic [CFG_W-1:0] res_data   = '0;
    logic             quiet      = 1'b0;
    int               mismatches;
    int               outstanding;
    int               stuck      = 0;

    int corner_list[18][4] = '{
        '{0, 0, 0, 0},
        '{0, 0, 1279, 1279},
        '{-2048, -2048, -2048, -2048},
        '{2047, 2047, 2047, 2047},
        '{-1, -1, 1280, 1280},
        '{1279, 1279, 1279, 1279},
        '{1280, 0, 1280, 0},
        '{639, 639, 640, 640},
        '{640, 640, 799, 799},
        '{160, 160, 319, 319},
        '{800, 0, 100, 500},
        '{1279, 1279, 0, 0},
        '{-2048, 2047, 2047, -2048},
        '{2047, -2048, -2048, 2047},
        '{159, 159, 160, 160},
        '{0, 1279, 1279, 0},
        '{1000, 1000, 1000, 1000},
        '{1, 2, 3, 4}
    };
    int res_plan[8] = '{8, 0, 15, 1, 9, 6, 2, 7};
    int rim_vals[9] = '{-2048, -1, 0, 1, 639, 640, 1279, 1280, 2047};

    always #2 clk = ~clk;

    linear_quadtree_cell_index_top dut (
        clk, rst_n, box_valid, box_stall, box_word, cell_valid, cell_stall, cell_word,
        res_valid, res_ready, res_data
    );

    cell_index_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .box_valid   (box_valid),
        .box_stall   (box_stall),
        .box_word    (box_word),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .cell_word   (cell_word),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(posedge clk)
    begin
        cell_stall <= !quiet && ($urandom_range(99) < 34);
    end

    always @(posedge clk)
    begin
        if ((box_valid && !box_stall) || (cell_valid && !cell_stall) || (res_valid && res_ready))
        begin
            stuck <= 0;
        end
        else
        begin
            stuck <= stuck + 1;
        end
        if (stuck >= STUCK_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic box_t make_box(int lx, int ty, int rx, int by);
        box_t b;
        b.left_x   = COORD_IN_W'(lx);
        b.top_y    = COORD_IN_W'(ty);
        b.right_x  = COORD_IN_W'(rx);
        b.bottom_y = COORD_IN_W'(by);
        return b;
    endfunction

    function automatic box_t random_box();
        int pick;
        int lx;
        int ty;
        int rx;
        int by;
        int span;
        int depth;
        int size;
        pick = $urandom_range(99);
        lx   = $urandom_range(0, FIELD_SIZE - 1);
        ty   = $urandom_range(0, FIELD_SIZE - 1);
        span = 1 << $urandom_range(0, 10);
        rx   = lx + $urandom_range(0, span - 1);
        by   = ty + $urandom_range(0, span - 1);
        if (rx > 2047)
        begin
            rx = 2047;
        end
        if (by > 2047)
        begin
            by = 2047;
        end
        if (pick < 45)
        begin
            return make_box(lx, ty, rx, by);
        end
        else if (pick < 60)
        begin
            depth = $urandom_range(1, MAX_LEVELS);
            size  = FIELD_SIZE >> depth;
            lx    = $urandom_range(0, (1 << depth) - 1) * size;
            ty    = $urandom_range(0, (1 << depth) - 1) * size;
            return make_box(lx, ty, lx + size - 1, ty + size - 1);
        end
        else if (pick < 75)
        begin
            return make_box(int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        end
        else if (pick < 87)
        begin
            case ($urandom_range(2))
                0: return make_box(rx, ty, lx, by);
                1: return make_box(lx, by, rx, ty);
                default: return make_box(rx, by, lx, ty);
            endcase
        end
        return make_box(rim_vals[$urandom_range(8)], rim_vals[$urandom_range(8)],
                        rim_vals[$urandom_range(8)], rim_vals[$urandom_range(8)]);
    endfunction

    task automatic send_box(box_t b);
        while (!quiet && $urandom_range(99) < 34)
        begin
            box_valid <= 1'b0;
            @(posedge clk);
        end
        box_valid <= 1'b1;
        box_word  <= b;
        do
            @(posedge clk);
        while (box_stall);
    endtask

    task automatic settle();
        box_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_resolution(logic [CFG_W-1:0] value);
        res_valid <= 1'b1;
        res_data  <= value;
        do
            @(posedge clk);
        while (!res_ready);
        res_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        foreach (corner_list[i])
        begin
            send_box(make_box(corner_list[i][0], corner_list[i][1],
                              corner_list[i][2], corner_list[i][3]));
        end
        for (int p = 0; p < 8; p++)
        begin
            settle();
            write_resolution(CFG_W'(res_plan[p]));
            quiet <= (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_box(random_box());
            end
        end
        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
